>>> rtl/core/lmgrs_pkg.sv
// Shared types, codes and constants for the LED matrix grey row scanner.
`timescale 1ns / 1ps

package lmgrs_pkg;

    localparam int ROWS    = 5;
    localparam int COLS    = 7;
    localparam int ROW_W   = 3;
    localparam int PHASE_W = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [COLS-1:0] MASK_ODD  = 7'h2A;
    localparam logic [COLS-1:0] MASK_EVEN = 7'h55;
    localparam logic [COLS-1:0] COL_ALL   = 7'h7F;
    localparam logic [ROWS-1:0] ROW_ALL   = 5'h1F;
    localparam logic [ROWS-1:0] ROW_FIRST = 5'h10;

    localparam logic [ROW_W-1:0]   LAST_ROW         = 3'd4;
    localparam logic [PHASE_W-1:0] SCAN_PERIOD_RST  = 8'd8;
    localparam logic [PHASE_W-1:0] GREY_WINDOW_RST  = 8'd4;

    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_WRITE_ON   = 2'd1,
        OP_WRITE_GREY = 2'd2,
        OP_FILL       = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        REG_DISPLAY_ENABLE  = 3'd0,
        REG_INVERT_ENABLE   = 3'd1,
        REG_SCRAMBLE_ENABLE = 3'd2,
        REG_COMMON_CATHODE  = 3'd3,
        REG_SCAN_PERIOD     = 3'd4,
        REG_GREY_WINDOW     = 3'd5,
        REG_SPARE_6         = 3'd6,
        REG_SPARE_7         = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic               display_enable;
        logic               invert_enable;
        logic               scramble_enable;
        logic               common_cathode;
        logic [PHASE_W-1:0] scan_period;
        logic [PHASE_W-1:0] grey_window;
    } t_cfg;

    typedef struct packed {
        logic [COLS-1:0]    on_bits;
        logic [COLS-1:0]    grey_bits;
        logic [PHASE_W-1:0] phase;
        logic [ROW_W-1:0]   row;
        logic               scramble_phase;
    } t_scan;

    function automatic logic [ROWS-1:0] row_onehot(input logic [ROW_W-1:0] row);
        row_onehot = ROW_FIRST >> row;
    endfunction

endpackage

>>> rtl/core/lmgrs_pixel.sv
// Pixel level logic: grey test, invert, scramble mask, display blanking and pin polarity.
`timescale 1ns / 1ps

module lmgrs_pixel
    import lmgrs_pkg::*;
(
    input  t_cfg            i_cfg,
    input  t_scan           i_scan,
    output logic [COLS-1:0] o_column_levels,
    output logic [ROWS-1:0] o_row_levels
);

    logic [COLS-1:0] lit;
    logic [ROWS-1:0] rowsel;

    always_comb begin
        lit = i_scan.on_bits;
        if (i_scan.phase < i_cfg.grey_window) begin
            lit = lit | i_scan.grey_bits;
        end
        if (i_cfg.invert_enable) begin
            lit = ~lit;
        end
        if (i_cfg.scramble_enable) begin
            lit = lit & (i_scan.scramble_phase ? MASK_ODD : MASK_EVEN);
        end
        rowsel = row_onehot(i_scan.row);
        if (!i_cfg.display_enable) begin
            lit    = '0;
            rowsel = '0;
        end
        if (i_cfg.common_cathode) begin
            o_column_levels = lit;
            o_row_levels    = ~rowsel;
        end else begin
            o_column_levels = ~lit;
            o_row_levels    = rowsel;
        end
    end

endmodule

>>> rtl/core/led_matrix_grey_row_scanner_core.sv
// Top level of the LED matrix grey row scanner: stores, scan state, output stage, APB port.
//
//  channel   dir  handshake                 payload
//  s_axis    in   i_s_tvalid / o_s_tready   i_s_tuser: opcode; i_s_tdata: row_index, row_bits
//  m_axis    out  o_m_tvalid / i_m_tready   o_m_tdata: column_levels, row_levels
//  apb       in   psel & penable & pwrite   paddr 4*index, pwdata, prdata, pready
//
// One item per cycle; a tick's result is registered, shown in the cycle after its transfer.
// Writes and fills give no result. The output register holds a result until
// taken, and the input keeps flowing as long as that register is free or drains.
// Synchronous active-low reset clears stores, scan state and valid; config gets defaults.
`timescale 1ns / 1ps

module led_matrix_grey_row_scanner_core
    import lmgrs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [1:0]        i_s_tuser,   // [1:0] opcode
    input  logic [15:0]       i_s_tdata,   // [2:0] row_index, [9:3] row_bits
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [15:0]       o_m_tdata,   // [6:0] column_levels, [11:7] row_levels
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output logic [DATA_W-1:0] o_prdata,
    output logic              o_pready
);

    t_cfg r_cfg;
    logic [COLS-1:0]    r_on_rows   [ROWS];
    logic [COLS-1:0]    r_grey_rows [ROWS];
    logic [PHASE_W-1:0] r_phase_count, n_phase_count;
    logic [ROW_W-1:0]   r_active_row, n_active_row;
    logic               r_scramble_phase, n_scramble_phase;
    logic               r_out_valid;
    logic [COLS-1:0]    r_column_levels;
    logic [ROWS-1:0]    r_row_levels;

    t_opcode          in_op;
    logic [ROW_W-1:0] in_idx;
    logic [COLS-1:0]  in_bits;
    logic             in_xfer;
    logic             tick_xfer;
    logic             cfg_wr;
    t_reg_idx         cfg_idx;
    t_scan            scan;
    logic [COLS-1:0]  column_levels;
    logic [ROWS-1:0]  row_levels;

    assign in_op    = t_opcode'(i_s_tuser);
    assign in_idx   = i_s_tdata[2:0];
    assign in_bits  = i_s_tdata[9:3];
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign in_xfer  = i_s_tvalid && o_s_tready;
    assign tick_xfer = in_xfer && (in_op == OP_TICK);

    assign o_pready = 1'b1;
    assign cfg_idx  = t_reg_idx'(i_paddr[4:2]);
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    always_comb begin
        unique case (cfg_idx)
            REG_DISPLAY_ENABLE:  o_prdata = {{(DATA_W-1){1'b0}}, r_cfg.display_enable};
            REG_INVERT_ENABLE:   o_prdata = {{(DATA_W-1){1'b0}}, r_cfg.invert_enable};
            REG_SCRAMBLE_ENABLE: o_prdata = {{(DATA_W-1){1'b0}}, r_cfg.scramble_enable};
            REG_COMMON_CATHODE:  o_prdata = {{(DATA_W-1){1'b0}}, r_cfg.common_cathode};
            REG_SCAN_PERIOD:     o_prdata = {{(DATA_W-PHASE_W){1'b0}}, r_cfg.scan_period};
            REG_GREY_WINDOW:     o_prdata = {{(DATA_W-PHASE_W){1'b0}}, r_cfg.grey_window};
            default:             o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.display_enable  <= 1'b1;
            r_cfg.invert_enable   <= 1'b0;
            r_cfg.scramble_enable <= 1'b0;
            r_cfg.common_cathode  <= 1'b0;
            r_cfg.scan_period     <= SCAN_PERIOD_RST;
            r_cfg.grey_window     <= GREY_WINDOW_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_DISPLAY_ENABLE:  r_cfg.display_enable  <= i_pwdata[0];
                REG_INVERT_ENABLE:   r_cfg.invert_enable   <= i_pwdata[0];
                REG_SCRAMBLE_ENABLE: r_cfg.scramble_enable <= i_pwdata[0];
                REG_COMMON_CATHODE:  r_cfg.common_cathode  <= i_pwdata[0];
                REG_SCAN_PERIOD:     r_cfg.scan_period     <= i_pwdata[PHASE_W-1:0];
                REG_GREY_WINDOW:     r_cfg.grey_window     <= i_pwdata[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    // Phase step and row advance; state holds while the display is off.
    always_comb begin
        n_phase_count    = r_phase_count;
        n_active_row     = r_active_row;
        n_scramble_phase = r_scramble_phase;
        if (r_cfg.display_enable) begin
            n_phase_count = r_phase_count + 1'b1;
            if (r_phase_count > r_cfg.scan_period) begin
                n_phase_count = '0;
                if (r_active_row >= LAST_ROW) begin
                    n_active_row     = '0;
                    n_scramble_phase = !r_scramble_phase;
                end else begin
                    n_active_row = r_active_row + 1'b1;
                end
            end
        end
        scan.on_bits        = r_on_rows[n_active_row];
        scan.grey_bits      = r_grey_rows[n_active_row];
        scan.phase          = n_phase_count;
        scan.row            = n_active_row;
        scan.scramble_phase = n_scramble_phase;
    end

    lmgrs_pixel u_pixel (
        .i_cfg           (r_cfg),
        .i_scan          (scan),
        .o_column_levels (column_levels),
        .o_row_levels    (row_levels)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                r_on_rows[i]   <= '0;
                r_grey_rows[i] <= '0;
            end
        end else if (in_xfer) begin
            for (int i = 0; i < ROWS; i++) begin
                unique case (in_op)
                    OP_WRITE_ON: begin
                        if (in_idx == ROW_W'(i)) r_on_rows[i] <= in_bits;
                    end
                    OP_WRITE_GREY: begin
                        if (in_idx == ROW_W'(i)) r_grey_rows[i] <= in_bits;
                    end
                    OP_FILL: begin
                        r_on_rows[i]   <= in_bits;
                        r_grey_rows[i] <= in_bits;
                    end
                    OP_TICK: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_count    <= '0;
            r_active_row     <= '0;
            r_scramble_phase <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (tick_xfer) begin
                r_phase_count    <= n_phase_count;
                r_active_row     <= n_active_row;
                r_scramble_phase <= n_scramble_phase;
                r_out_valid      <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_xfer) begin
            r_column_levels <= column_levels;
            r_row_levels    <= row_levels;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_row_levels, r_column_levels};

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active_row <= LAST_ROW)
        else $error("active row out of range");

    a_row_anode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_cfg.common_cathode |-> $onehot0(r_row_levels))
        else $error("more than one row driven (anode)");

    a_row_cathode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_cfg.common_cathode |-> $onehot0(~r_row_levels))
        else $error("more than one row driven (cathode)");

    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_xfer && r_cfg.display_enable && (r_phase_count <= r_cfg.scan_period)
        |=> r_phase_count == PHASE_W'($past(r_phase_count) + 1'b1))
        else $error("phase did not step");

endmodule
